/* hw/rtl/khr_pkg.sv */
// Package for the keyword hash recognizer: widths, scan phase and outcome codes,
// keyword register defaults. No dependencies.
`default_nettype none
package khr_pkg;
	localparam int NUM_KEYS          = 5;
	localparam int KEY_W             = 56;
	localparam int HASH_W            = 57;
	localparam int KIDX_W            = 3;
	localparam int MAX_TOKEN_LEN_DEF = 8;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] CHAR_BIAS  = 8'h80;

	typedef enum logic [3:0] {
		PH_LEAD  = 4'b0001,
		PH_WORD  = 4'b0010,
		PH_TRAIL = 4'b0100,
		PH_BAD   = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		OUT_EMPTY   = 2'd0,
		OUT_FOUND   = 2'd1,
		OUT_INVALID = 2'd2
	} outcome_t;

	typedef struct packed {
		phase_t              phase;
		logic [HASH_W-1:0]   hash;
	} scan_t;

	function automatic logic [KEY_W-1:0] key_default(input logic [KIDX_W-1:0] idx);
		logic [KEY_W-1:0] v;
		unique case (idx)
			3'd0:    v = 56'd1031525449954;
			3'd1:    v = 56'd4045201410;
			3'd2:    v = 56'd66783903468228079;
			3'd3:    v = 56'd263038989868818;
			3'd4:    v = 56'd3813320734;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/khr_scan.sv */
// Line scanner: phase tracking, word length and rolling hash update.
// Depends on khr_pkg.
`default_nettype none
module khr_scan #(
	parameter int MAX_TOKEN_LEN = khr_pkg::MAX_TOKEN_LEN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    char_byte,
	input  wire logic          end_of_line,
	output khr_pkg::scan_t     scan
);
	import khr_pkg::*;

	localparam int LEN_W = (MAX_TOKEN_LEN > 2) ? $clog2(MAX_TOKEN_LEN) : 1;
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_TOKEN_LEN - 1);

	phase_t            phase_q, phase_d;
	logic [HASH_W-1:0] hash_q, hash_d, hash_next;
	logic [LEN_W-1:0]  len_q, len_d;
	logic              is_space;

	assign is_space = (char_byte == SPACE_CHAR);
	// hash*255 + (byte ^ 0x80), modulo 2^HASH_W
	assign hash_next = {hash_q[HASH_W-9:0], 8'h00} - hash_q
		+ {{(HASH_W-8){1'b0}}, char_byte ^ CHAR_BIAS};

	always_comb begin
		phase_d = phase_q;
		hash_d  = hash_q;
		len_d   = len_q;
		if (end_of_line) begin
			phase_d = PH_LEAD;
			hash_d  = '0;
			len_d   = '0;
		end else begin
			unique case (phase_q)
				PH_LEAD, PH_WORD: begin
					if (phase_q == PH_WORD && is_space) begin
						phase_d = PH_TRAIL;
					end else if (!is_space) begin
						phase_d = PH_WORD;
						hash_d  = hash_next;
						if (len_q == LEN_LAST) begin
							phase_d = PH_BAD;
							len_d   = '0;
						end else begin
							len_d = len_q + 1'b1;
						end
					end
				end
				PH_TRAIL: begin
					if (!is_space) phase_d = PH_BAD;
				end
				PH_BAD: ;
				default: phase_d = PH_BAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			hash_q  <= '0;
			len_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			hash_q  <= hash_d;
			len_q   <= len_d;
		end
	end

	assign scan = '{phase: phase_q, hash: hash_q};
endmodule
`default_nettype wire

/* hw/rtl/keyword_hash_recognizer_top.sv */
// Keyword hash recognizer top level: keyword registers, match logic, result register.
// Depends on khr_pkg and khr_scan.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one character per request in
//    char_byte; a request with end_of_line set closes the line.
//  - Only an end-of-line request yields a result on the output channel
//    (out_valid/out_ready): outcome (empty, found, invalid) and keyword_index.
//  - The result is registered: it is valid the cycle after the end-of-line request.
//  - Throughput: one request per cycle while in_ready is high; the hash update is a shift-subtract-add
//    and the five keyword compares run in parallel on the registered hash.
//  - A finished result sits in the output register while the next line's
//    characters are still taken; in_ready drops only while that register is
//    full and out_ready is low.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes keyword hash
//    registers 0..4; other indexes are ignored. cfg_ready is always high.
//  - Reset (arst_n low) returns the scanner to the leading-space phase with a
//    zero hash, empties the output register and restores the default keywords.
`default_nettype none
module keyword_hash_recognizer_top #(
	parameter int MAX_TOKEN_LEN = khr_pkg::MAX_TOKEN_LEN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [7:0]                  char_byte,
	input  wire logic                        end_of_line,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       outcome,
	output logic [2:0]                       keyword_index,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [khr_pkg::KIDX_W-1:0]  cfg_index,
	input  wire logic [khr_pkg::KEY_W-1:0]   cfg_data
);
	import khr_pkg::*;

	logic [KEY_W-1:0]  key_q [NUM_KEYS];
	scan_t             scan_st;
	logic              acc;
	logic              out_valid_q;
	outcome_t          outcome_q, outcome_d;
	logic [KIDX_W-1:0] kidx_q, kidx_d;
	logic              hit;
	logic [KIDX_W-1:0] hit_idx;

	assign acc       = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	khr_scan #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (acc),
		.char_byte   (char_byte),
		.end_of_line (end_of_line),
		.scan        (scan_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) key_q[i] <= key_default(KIDX_W'(i));
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				if (cfg_index == KIDX_W'(i)) key_q[i] <= cfg_data;
			end
		end
	end

	// lowest matching index wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (scan_st.hash == {1'b0, key_q[i]}) begin
				hit     = 1'b1;
				hit_idx = KIDX_W'(i);
			end
		end
	end

	always_comb begin
		outcome_d = OUT_INVALID;
		kidx_d    = '0;
		priority if (scan_st.phase == PH_BAD) begin
			outcome_d = OUT_INVALID;
		end else if (scan_st.hash == '0) begin
			outcome_d = OUT_EMPTY;
		end else if (hit) begin
			outcome_d = OUT_FOUND;
			kidx_d    = hit_idx;
		end else begin
			outcome_d = OUT_INVALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && end_of_line) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && end_of_line) begin
			outcome_q <= outcome_d;
			kidx_q    <= kidx_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = outcome_q;
	assign keyword_index = kidx_q;

	a_result_from_eol: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && end_of_line))
		else $error("result without end-of-line request");

	a_index_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != OUT_FOUND) |-> keyword_index == '0)
		else $error("keyword index set on non-match");

	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		acc && end_of_line |=> scan_st.phase == PH_LEAD && scan_st.hash == '0)
		else $error("scanner not cleared after end of line");
endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench for keyword_hash_recognizer_top, depends on khr_pkg. Directed lines, then random
// lines under several keyword settings, checked by a scan and hash predictor or the table.

module tb;
	import khr_pkg::*;

	localparam int MAX_LEN     = MAX_TOKEN_LEN_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 170;
	localparam int N_DIRECTED  = 21;
	localparam logic [KEY_W-1:0] KEY_RESET [NUM_KEYS] = '{
		56'd1031525449954, 56'd4045201410, 56'd66783903468228079,
		56'd263038989868818, 56'd3813320734
	};

	typedef logic [7:0] word_t [$];

	typedef struct packed {
		logic [7:0]  ch;
		logic        eol;
		logic        typed;
		outcome_t    oc;
		logic [2:0]  idx;
	} char_req_t;

	typedef struct packed {
		outcome_t    oc;
		logic [2:0]  idx;
	} verdict_t;

	typedef struct packed {
		logic [KIDX_W-1:0] idx;
		logic [KEY_W-1:0]  data;
	} key_write_t;

	typedef struct {
		string       text;
		logic [7:0]  fill;
		int          fill_n;
		bit          typed;
		outcome_t    oc;
		int          idx;
	} line_row_t;

	line_row_t directed_lines [N_DIRECTED] = '{
		'{"",            8'h00, 0, 1'b1, OUT_EMPTY,   0},
		'{"    ",        8'h00, 0, 1'b1, OUT_EMPTY,   0},
		'{"start",       8'h00, 0, 1'b1, OUT_FOUND,   0},
		'{"stop",        8'h00, 0, 1'b1, OUT_FOUND,   1},
		'{"restart",     8'h00, 0, 1'b1, OUT_FOUND,   2},
		'{"status",      8'h00, 0, 1'b1, OUT_FOUND,   3},
		'{"exit",        8'h00, 0, 1'b1, OUT_FOUND,   4},
		'{"   stop  ",   8'h00, 0, 1'b1, OUT_FOUND,   1},
		'{"stop x",      8'h00, 0, 1'b1, OUT_INVALID, 0},
		'{"restarts",    8'h00, 0, 1'b1, OUT_INVALID, 0},
		'{"abcdefghijk", 8'h00, 0, 1'b1, OUT_INVALID, 0},
		'{"",            8'h80, 3, 1'b1, OUT_EMPTY,   0},
		'{"  ",          8'h80, 7, 1'b1, OUT_EMPTY,   0},
		'{"",            8'h80, 8, 1'b1, OUT_INVALID, 0},
		'{"",            8'h00, 1, 1'b0, OUT_EMPTY,   0},
		'{"",            8'hFF, 7, 1'b0, OUT_EMPTY,   0},
		'{"exit ",       8'h00, 1, 1'b1, OUT_INVALID, 0},
		'{"START",       8'h00, 0, 1'b0, OUT_EMPTY,   0},
		'{"a",           8'h00, 0, 1'b0, OUT_EMPTY,   0},
		'{"x  y",        8'h00, 0, 1'b1, OUT_INVALID, 0},
		'{"",            8'h7F, 2, 1'b0, OUT_EMPTY,   0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          char_byte = 8'h00;
	logic                end_of_line = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          outcome;
	logic [2:0]          keyword_index;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [KIDX_W-1:0]   cfg_index = '0;
	logic [KEY_W-1:0]    cfg_data = '0;

	char_req_t           line_q [$];
	verdict_t            verdict_q [$];
	char_req_t           cur_req;
	verdict_t            got_v;
	word_t               vocab [NUM_KEYS];

	phase_t              scan_phase = PH_LEAD;
	logic [HASH_W-1:0]   scan_hash = '0;
	int                  word_len = 0;
	logic [KEY_W-1:0]    key_regs [NUM_KEYS] = KEY_RESET;

	int                  errors = 0;
	int                  reqs_outstanding = 0;
	int                  reqs_accepted = 0;
	int                  items_total = 0;
	int                  stall_cycles = 0;
	logic                steady;

	assign steady = (reqs_accepted >= 450) && (reqs_accepted < 700);

	keyword_hash_recognizer_top #(
		.MAX_TOKEN_LEN(MAX_LEN)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_byte     (char_byte),
		.end_of_line   (end_of_line),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.outcome       (outcome),
		.keyword_index (keyword_index),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [HASH_W-1:0] hash_add(input logic [HASH_W-1:0] h,
			input logic [7:0] b);
		logic [HASH_W-1:0] r;
		r = h * 57'd255 + {49'd0, b ^ CHAR_BIAS};
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] word_hash(input word_t w);
		logic [HASH_W-1:0] h;
		h = '0;
		foreach (w[k])
			h = hash_add(h, w[k]);
		return h[KEY_W-1:0];
	endfunction

	function automatic word_t rand_word(input int n);
		word_t w;
		logic [7:0] b;
		repeat (n) begin
			do b = 8'($urandom_range(0, 255)); while (b == SPACE_CHAR);
			w.push_back(b);
		end
		return w;
	endfunction

	task automatic add_word_char(input logic [7:0] b);
		scan_hash = hash_add(scan_hash, b);
		word_len++;
		if (word_len >= MAX_LEN) begin
			scan_phase = PH_BAD;
			word_len = 0;
		end
	endtask

	task automatic track_request(input char_req_t r);
		verdict_t v;
		int i;
		if (r.eol) begin
			v.oc = OUT_INVALID;
			v.idx = '0;
			if (scan_phase != PH_BAD) begin
				if (scan_hash == '0) begin
					v.oc = OUT_EMPTY;
				end else begin
					for (i = NUM_KEYS - 1; i >= 0; i--) begin
						if (scan_hash == {1'b0, key_regs[i]}) begin
							v.oc = OUT_FOUND;
							v.idx = 3'(i);
						end
					end
				end
			end
			if (r.typed) begin
				v.oc = r.oc;
				v.idx = r.idx;
			end
			verdict_q.push_back(v);
			scan_phase = PH_LEAD;
			scan_hash = '0;
			word_len = 0;
		end else begin
			case (scan_phase)
				PH_LEAD: if (r.ch != SPACE_CHAR) begin
					scan_phase = PH_WORD;
					add_word_char(r.ch);
				end
				PH_WORD: if (r.ch == SPACE_CHAR) begin
					scan_phase = PH_TRAIL;
				end else begin
					add_word_char(r.ch);
				end
				PH_TRAIL: if (r.ch != SPACE_CHAR) begin
					scan_phase = PH_BAD;
				end
				default: ;
			endcase
		end
	endtask

	task automatic push_line(input word_t chars, input bit typed, input outcome_t oc,
			input logic [2:0] idx);
		char_req_t r;
		foreach (chars[k]) begin
			r = '{ch: chars[k], eol: 1'b0, typed: 1'b0, oc: OUT_EMPTY, idx: 3'd0};
			line_q.push_back(r);
		end
		r = '{ch: 8'($urandom_range(0, 255)), eol: 1'b1, typed: typed, oc: oc, idx: idx};
		line_q.push_back(r);
		reqs_outstanding += chars.size() + 1;
		items_total += chars.size() + 1;
	endtask

	task automatic random_line();
		word_t chars;
		word_t w;
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			n = $urandom_range(0, 12);
			repeat (n)
				chars.push_back(($urandom_range(0, 99) < 30) ? SPACE_CHAR
						: 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) chars.push_back(SPACE_CHAR);
			if (kind < 68) begin
				w = vocab[$urandom_range(0, NUM_KEYS - 1)];
			end else if (kind < 90) begin
				w = rand_word($urandom_range(1, MAX_LEN + 1));
			end else begin
				repeat ($urandom_range(1, MAX_LEN)) w.push_back(CHAR_BIAS);
			end
			foreach (w[k])
				chars.push_back(w[k]);
			repeat ($urandom_range(0, 2)) chars.push_back(SPACE_CHAR);
			if ($urandom_range(0, 9) == 0) begin
				chars.push_back(SPACE_CHAR);
				w = rand_word(1);
				chars.push_back(w[0]);
			end
		end
		push_line(chars, 1'b0, OUT_EMPTY, 3'd0);
	endtask

	// keyword writes in random order, with out-of-range indexes mixed in
	task automatic program_keys(input logic [KEY_W-1:0] vals [NUM_KEYS]);
		key_write_t wq [$];
		key_write_t w;
		int i;
		for (i = 0; i < NUM_KEYS; i++) begin
			w = '{idx: KIDX_W'(i), data: vals[i]};
			wq.insert($urandom_range(0, wq.size()), w);
		end
		repeat ($urandom_range(1, 3)) begin
			w = '{idx: KIDX_W'($urandom_range(NUM_KEYS, 7)),
					data: KEY_W'({$urandom, $urandom})};
			wq.insert($urandom_range(0, wq.size()), w);
		end
		foreach (wq[k]) begin
			cfg_valid <= 1'b1;
			cfg_index <= wq[k].idx;
			cfg_data <= wq[k].data;
			do @(posedge clk); while (!cfg_ready);
			if (wq[k].idx < NUM_KEYS)
				key_regs[wq[k].idx] = wq[k].data;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (reqs_outstanding != 0 || verdict_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				track_request(cur_req);
				reqs_outstanding--;
				reqs_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (line_q.size() != 0 && (steady || $urandom_range(0, 99) >= 8)) begin
					cur_req = line_q.pop_front();
					in_valid <= 1'b1;
					char_byte <= cur_req.ch;
					end_of_line <= cur_req.eol;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result: outcome %0d, keyword_index %0d",
						outcome, keyword_index);
				errors++;
			end else begin
				got_v = verdict_q.pop_front();
				if (outcome !== got_v.oc) begin
					$error("outcome: expected %0d, got %0d", got_v.oc, outcome);
					errors++;
				end
				if (keyword_index !== got_v.idx) begin
					$error("keyword_index: expected %0d, got %0d", got_v.idx, keyword_index);
					errors++;
				end
			end
		end
		out_ready <= arst_n && (steady || $urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [KEY_W-1:0] vals [NUM_KEYS];
		word_t chars;
		int ph;
		int i;
		int a;
		int b;
		int k;
		int phase_start;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_lines[r]) begin
			chars.delete();
			for (k = 0; k < directed_lines[r].text.len(); k++)
				chars.push_back(directed_lines[r].text[k]);
			repeat (directed_lines[r].fill_n) chars.push_back(directed_lines[r].fill);
			push_line(chars, directed_lines[r].typed, directed_lines[r].oc,
					3'(directed_lines[r].idx));
		end
		wait_idle();

		for (ph = 1; ph <= 6; ph++) begin
			for (i = 0; i < NUM_KEYS; i++) begin
				vocab[i] = rand_word($urandom_range(1, MAX_LEN - 1));
				vals[i] = word_hash(vocab[i]);
			end
			if (ph == 1) begin
				vals[0] = '1;
				vals[1] = '0;
				vocab[4] = vocab[2];
				vals[4] = vals[2];
			end else if (ph == 2) begin
				for (i = 0; i < NUM_KEYS; i++)
					vals[i] = '0;
			end else begin
				if ($urandom_range(0, 99) < 30) begin
					a = $urandom_range(0, NUM_KEYS - 2);
					b = $urandom_range(a + 1, NUM_KEYS - 1);
					vocab[b] = vocab[a];
					vals[b] = vals[a];
				end
				if ($urandom_range(0, 99) < 15)
					vals[$urandom_range(0, NUM_KEYS - 1)] = '0;
			end
			program_keys(vals);
			phase_start = items_total;
			while (items_total - phase_start < PHASE_ITEMS)
				random_line();
			wait_idle();
		end

		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule

/* keyword_hash_recognizer_top.f */
hw/rtl/khr_pkg.sv
hw/rtl/khr_scan.sv
hw/rtl/keyword_hash_recognizer_top.sv
test/tb.sv
